### hw/rtl/stbs_pkg.sv
package stbs_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned IDX_W           = 10;
  localparam int unsigned SIZE_W          = 11;
  localparam int unsigned DATA_W          = 32;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE = 1'b1;

  // item commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // search modes
  localparam logic MODE_THREE_WAY   = 1'b0;
  localparam logic MODE_LOWER_BOUND = 1'b1;

endpackage

### hw/rtl/sorted_table_binary_search_unit.sv
// Sorted table binary search unit.
// Items arrive on start/busy: an item is taken at a clock edge with start high
// and busy low. A write item (in_cmd = write) stores in_entry_value at
// in_entry_index and gives no result. A search item looks up in_search_key
// among the first table_size entries and gives one result (out_found,
// out_match_index) marked by out_valid for exactly one cycle.
// A search makes one table probe per cycle against the single read port of
// the table memory; in lower-bound mode a final check of the lower-bound
// entry follows when it lies inside the table. An empty table answers in
// the cycle after the search is taken. The result appears the cycle after
// the last probe and busy drops with it, so the next item may follow.
// The configuration port (cfg_we, cfg_index, cfg_wdata) sets table_size
// and search_mode; write it only while busy is low.
// Reset clears the control state and both registers; the table contents are
// undefined until written. The receiver cannot stall: results are not held.
module sorted_table_binary_search_unit #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_cmd,
  input  logic [stbs_pkg::IDX_W-1:0]          in_entry_index,
  input  logic signed [stbs_pkg::DATA_W-1:0]  in_entry_value,
  input  logic signed [stbs_pkg::DATA_W-1:0]  in_search_key,
  output logic                                out_valid,
  output logic                                out_found,
  output logic [stbs_pkg::IDX_W-1:0]          out_match_index,
  input  logic                                cfg_we,
  input  logic [stbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stbs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import stbs_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = ($clog2(TABLE_DEPTH + 1) > SIZE_W) ?
                               $clog2(TABLE_DEPTH + 1) : SIZE_W;
  localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_CHECK  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]        table_size_r;
  logic                     search_mode_r;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic [NW-1:0]            low_r, low_nxt;
  logic [NW-1:0]            end_r, end_nxt;     // exclusive upper end of range
  logic [NW-1:0]            mid_r, mid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_found_r, out_found_nxt;
  logic [IDX_W-1:0]         out_index_r, out_index_nxt;

  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [NW-1:0]            wr_idx_ext;
  logic [NW-1:0]            used_n;
  logic [NW-1:0]            ts_ext;
  logic                     accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r  <= '0;
      search_mode_r <= MODE_THREE_WAY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_SIZE:  table_size_r  <= cfg_wdata;
        REG_SEARCH_MODE: search_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // entries in use, clipped to the table depth
  assign ts_ext = NW'(table_size_r);
  assign used_n = (ts_ext > DEPTH_N) ? DEPTH_N : ts_ext;

  assign accept     = start && (state_r == ST_IDLE);
  assign wr_idx_ext = NW'(in_entry_index);
  assign wr_en      = accept && (in_cmd == CMD_WRITE) && (wr_idx_ext < DEPTH_N);

  // table memory, one write and one read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx_ext[AW-1:0]] <= in_entry_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // search sequencer: one probe per cycle
  always_comb begin
    logic [NW-1:0] lo_t;
    logic [NW-1:0] en_t;
    logic [NW-1:0] half_t;
    state_nxt     = state_r;
    key_nxt       = key_r;
    low_nxt       = low_r;
    end_nxt       = end_r;
    mid_nxt       = mid_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = 1'b0;
    out_index_nxt = '0;
    lo_t          = low_r;
    en_t          = end_r;
    half_t        = '0;
    rd_addr       = mid_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_cmd == CMD_SEARCH)) begin
          key_nxt = in_search_key;
          low_nxt = '0;
          end_nxt = used_n;
          if (used_n == '0) begin
            out_valid_nxt = 1'b1;
          end else begin
            mid_nxt   = (used_n - NW'(1)) >> 1;
            rd_addr   = mid_nxt[AW-1:0];
            state_nxt = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (search_mode_r == MODE_THREE_WAY) begin
          if (key_r < rd_data_r) begin
            en_t = mid_r;
          end else if (key_r > rd_data_r) begin
            lo_t = mid_r + NW'(1);
          end
        end else begin
          if (key_r <= rd_data_r) begin
            en_t = mid_r;
          end else begin
            lo_t = mid_r + NW'(1);
          end
        end
        low_nxt = lo_t;
        end_nxt = en_t;
        half_t  = (en_t - lo_t - NW'(1)) >> 1;

        if ((search_mode_r == MODE_THREE_WAY) && (key_r == rd_data_r)) begin
          // exact hit ends a three-way search at once
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_index_nxt = mid_r[IDX_W-1:0];
          state_nxt     = ST_IDLE;
        end else if (lo_t < en_t) begin
          mid_nxt = lo_t + half_t;
          rd_addr = mid_nxt[AW-1:0];
        end else if ((search_mode_r == MODE_LOWER_BOUND) && (lo_t < used_n)) begin
          // range closed: fetch the lower-bound entry for the final check
          rd_addr   = lo_t[AW-1:0];
          state_nxt = ST_CHECK;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_CHECK: begin
        out_valid_nxt = 1'b1;
        if (rd_data_r == key_r) begin
          out_found_nxt = 1'b1;
          out_index_nxt = low_r[IDX_W-1:0];
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // search payload and result registers
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    low_r       <= low_nxt;
    end_r       <= end_nxt;
    mid_r       <= mid_nxt;
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_index_r;

endmodule

### tb/sorted_table_binary_search_unit_tb.sv
module sorted_table_binary_search_unit_tb;
  import stbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 24;
  localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } lookup_t;

  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     start           = 1'b0;
  logic                     busy;
  logic                     in_cmd          = CMD_WRITE;
  logic [IDX_W-1:0]         in_entry_index  = '0;
  logic signed [DATA_W-1:0] in_entry_value  = '0;
  logic signed [DATA_W-1:0] in_search_key   = '0;
  logic                     out_valid;
  logic                     out_found;
  logic [IDX_W-1:0]         out_match_index;
  logic                     cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index       = REG_TABLE_SIZE;
  logic [CFG_DATA_W-1:0]    cfg_wdata       = '0;

  // shadow copy of the table and registers
  logic signed [DATA_W-1:0] shadow_table [TABLE_DEPTH_DEF];
  logic [SIZE_W-1:0]        shadow_size = '0;
  logic                     shadow_mode = MODE_THREE_WAY;

  lookup_t lookups_due [$];
  lookup_t oldest_lookup;

  int idle_pct        = 38;
  int items_sent      = 0;
  int writes_sent     = 0;
  int searches_sent   = 0;
  int results_checked = 0;
  int settings_tried  = 0;
  int mismatches      = 0;
  int quiet_cycles    = 0;

  sorted_table_binary_search_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_search_key   (in_search_key),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_match_index (out_match_index),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // expected lookup result for a key against the shadow table
  function automatic lookup_t binary_lookup(input logic signed [DATA_W-1:0] key);
    int used;
    int lo;
    int hi;
    int mid;
    lookup_t res;
    used = (shadow_size > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(shadow_size);
    lo = 0;
    hi = used - 1;
    res = '0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_mode == MODE_THREE_WAY) begin
        if (key < shadow_table[mid]) begin
          hi = mid - 1;
        end else if (key > shadow_table[mid]) begin
          lo = mid + 1;
        end else begin
          res.found = 1'b1;
          res.index = IDX_W'(mid);
          return res;
        end
      end else begin
        if (key <= shadow_table[mid]) hi = mid - 1;
        else lo = mid + 1;
      end
    end
    // lower bound ends on the first entry not below the key
    if (shadow_mode == MODE_LOWER_BOUND && lo < used && shadow_table[lo] == key) begin
      res.found = 1'b1;
      res.index = IDX_W'(lo);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // present one item, idling at random first, and update the shadow on accept
  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] value,
                           input logic signed [DATA_W-1:0] key);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start          <= 1'b0;
      in_cmd         <= 1'($urandom);
      in_entry_index <= IDX_W'($urandom);
      in_entry_value <= $urandom;
      in_search_key  <= $urandom;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_entry_index <= idx;
    in_entry_value <= value;
    in_search_key  <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (cmd == CMD_WRITE) begin
      shadow_table[idx] = value;
      writes_sent++;
    end else begin
      lookups_due.push_back(binary_lookup(key));
      searches_sent++;
    end
  endtask

  task automatic send_write(input logic [IDX_W-1:0] idx, input logic signed [DATA_W-1:0] value);
    send_item(CMD_WRITE, idx, value, $urandom);
  endtask

  task automatic send_search(input logic signed [DATA_W-1:0] key);
    send_item(CMD_SEARCH, IDX_W'($urandom), $urandom, key);
  endtask

  // register write once all lookups are back and the block has settled
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    start <= 1'b0;
    while (lookups_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TABLE_SIZE) shadow_size = data;
    else shadow_mode = data[0];
    settings_tried++;
  endtask

  // fill entries 0..n-1 in ascending order, with runs of duplicates
  task automatic load_sorted_table(input int n, input bit dense);
    longint cur;
    longint stride;
    int i;
    if (dense) begin
      stride = 1;
      cur = -longint'($urandom_range(20));
    end else begin
      stride = (longint'(1) << 32) / (n + 1);
      cur = -(longint'(1) << 31);
      if ($urandom_range(7) != 0) cur += longint'($urandom_range(unsigned'(32'(stride))));
    end
    for (i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(3) != 0)
        cur += longint'($urandom_range(unsigned'(32'(2 * stride))));
      if (cur > longint'(VALUE_MAX) || (i == n - 1 && $urandom_range(7) == 0))
        cur = longint'(VALUE_MAX);
      send_write(IDX_W'(i), DATA_W'(cur));
    end
  endtask

  // mostly searches aimed at stored keys, with some writes mixed in
  task automatic send_random_traffic(input int n);
    int pick;
    int used;
    int j;
    logic signed [DATA_W-1:0] key;
    pick = $urandom_range(99);
    used = (n > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : n;
    key = $urandom;
    if (pick < 10 && used < TABLE_DEPTH_DEF) begin
      send_write(IDX_W'($urandom_range(TABLE_DEPTH_DEF - 1, used)), $urandom);
    end else if (pick < 14 && used > 0) begin
      // breaks the ordering of the used part
      send_write(IDX_W'($urandom_range(used - 1)), $urandom);
    end else begin
      if (used > 0 && pick < 70) begin
        j = $urandom_range(used - 1);
        key = shadow_table[j];
        if (pick >= 62) key = key - 1;
        else if (pick >= 55) key = key + 1;
      end
      send_search(key);
    end
  endtask

  task automatic test_empty_table;
    send_search('0);
    write_register(REG_SEARCH_MODE, CFG_DATA_W'(MODE_LOWER_BOUND));
    send_search(VALUE_MAX);
  endtask

  task automatic test_three_way;
    write_register(REG_TABLE_SIZE, CFG_DATA_W'(6));
    write_register(REG_SEARCH_MODE, CFG_DATA_W'(MODE_THREE_WAY));
    send_write(IDX_W'(0), VALUE_MIN);
    send_write(IDX_W'(1), -5);
    send_write(IDX_W'(2), -5);
    send_write(IDX_W'(3), 7);
    send_write(IDX_W'(4), 7);
    send_write(IDX_W'(5), VALUE_MAX);
    send_write({IDX_W{1'b1}}, {DATA_W{1'b1}});
    send_search(VALUE_MIN);
    send_search(VALUE_MAX);
    send_search(7);
    send_search(-5);
    send_search(0);
  endtask

  task automatic test_lower_bound;
    write_register(REG_SEARCH_MODE, CFG_DATA_W'(MODE_LOWER_BOUND));
    send_search(7);
    send_search(-5);
    send_search(VALUE_MIN);
    send_search(3);
    // key above every entry runs low off the end
    send_write(IDX_W'(5), 100);
    send_search(VALUE_MAX);
  endtask

  task automatic test_unsorted;
    send_write(IDX_W'(1), VALUE_MAX);
    send_search(-5);
    write_register(REG_SEARCH_MODE, CFG_DATA_W'(MODE_THREE_WAY));
    send_search(7);
  endtask

  task automatic test_full_depth;
    write_register(REG_TABLE_SIZE, CFG_DATA_W'(TABLE_DEPTH_DEF));
    write_register(REG_SEARCH_MODE, CFG_DATA_W'(MODE_THREE_WAY));
    load_sorted_table(TABLE_DEPTH_DEF, 1'b0);
    repeat (30) send_random_traffic(TABLE_DEPTH_DEF);
    write_register(REG_SEARCH_MODE, CFG_DATA_W'(MODE_LOWER_BOUND));
    repeat (30) send_random_traffic(TABLE_DEPTH_DEF);
    // sizes above the depth are clamped to it
    write_register(REG_TABLE_SIZE, {CFG_DATA_W{1'b1}});
    repeat (20) send_random_traffic(TABLE_DEPTH_DEF);
    write_register(REG_TABLE_SIZE, CFG_DATA_W'(TABLE_DEPTH_DEF + 1));
    write_register(REG_SEARCH_MODE, CFG_DATA_W'(MODE_THREE_WAY));
    repeat (20) send_random_traffic(TABLE_DEPTH_DEF);
  endtask

  task automatic test_random_settings(input int item_budget);
    int first;
    int n;
    int r;
    first = items_sent;
    while (items_sent - first < item_budget) begin
      r = $urandom_range(99);
      if (r < 8) n = 0;
      else if (r < 16) n = 1;
      else if (r < 80) n = $urandom_range(24, 2);
      else if (r < 95) n = $urandom_range(100, 25);
      else n = $urandom_range(200, 101);
      write_register(REG_TABLE_SIZE, CFG_DATA_W'(n));
      // upper data bits are random, only bit 0 selects the mode
      write_register(REG_SEARCH_MODE, CFG_DATA_W'($urandom));
      load_sorted_table(n, $urandom_range(2) == 0);
      repeat ($urandom_range(40, 20)) send_random_traffic(n);
    end
  endtask

  // compare each result with the oldest pending lookup
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (lookups_due.size() == 0) begin
        report_mismatch($sformatf("result with no lookup pending: found=%0b index=%0d",
                                  out_found, out_match_index));
      end else begin
        oldest_lookup = lookups_due.pop_front();
        if (out_found !== oldest_lookup.found)
          report_mismatch($sformatf("lookup %0d: found=%0b, expected %0b",
                                    results_checked, out_found, oldest_lookup.found));
        if (out_match_index !== oldest_lookup.index)
          report_mismatch($sformatf("lookup %0d: match_index=%0d, expected %0d",
                                    results_checked, out_match_index, oldest_lookup.index));
        results_checked++;
      end
    end
  end

  // watchdog on cycles with no item and no result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no activity for %0d cycles", WATCHDOG_LIMIT);
        $display("sorted_table_binary_search_unit_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 38;
    test_empty_table;
    test_three_way;
    test_lower_bound;
    test_unsorted;
    test_full_depth;
    test_random_settings(35);
    idle_pct = 65;
    test_random_settings(35);
    idle_pct = 0;
    test_random_settings(35);

    // let the last lookups come back, then watch for strays
    @(negedge clk);
    start <= 1'b0;
    while (lookups_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d writes, %0d searches), %0d lookups checked",
             items_sent, writes_sent, searches_sent, results_checked);
    $display("over %0d register writes: empty, small, full and clamped tables, both modes",
             settings_tried);
    if (mismatches == 0) begin
      $display("sorted_table_binary_search_unit_tb: done, clean");
    end else begin
      $display("sorted_table_binary_search_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

### sorted_table_binary_search_unit.f
hw/rtl/stbs_pkg.sv
hw/rtl/sorted_table_binary_search_unit.sv
tb/sorted_table_binary_search_unit_tb.sv
